/* rtl/mi3_pkg.sv */
`timescale 1ns / 1ps
// Package for the 3x3 matrix inverse core: widths, beat payload types and
// the stage records passed between the pipeline modules. No dependencies.
package mi3_pkg;

  localparam int EW  = 32;  // Q16.16 element
  localparam int NE  = 9;   // elements per matrix
  localparam int PW  = 64;  // element product
  localparam int CW  = 65;  // signed cofactor, Q33.32
  localparam int CMW = 64;  // cofactor magnitude
  localparam int HW  = 33;  // upper cofactor slice for the determinant products
  localparam int XW  = EW + HW; // determinant partial product
  localparam int DW  = 97;  // signed determinant, Q49.48
  localparam int MW  = 96;  // determinant magnitude and remainder
  localparam int NQ  = 32;  // quotient bits

  localparam logic [EW-1:0] POS_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] NEG_MAX = {1'b1, {(EW-1){1'b0}}};

  typedef struct packed {
    logic [EW-1:0] in_r1c1;
    logic [EW-1:0] in_r1c2;
    logic [EW-1:0] in_r1c3;
    logic [EW-1:0] in_r2c1;
    logic [EW-1:0] in_r2c2;
    logic [EW-1:0] in_r2c3;
    logic [EW-1:0] in_r3c1;
    logic [EW-1:0] in_r3c2;
    logic [EW-1:0] in_r3c3;
  } mi3_in_t;

  typedef struct packed {
    logic [EW-1:0] inv_r1c1;
    logic [EW-1:0] inv_r1c2;
    logic [EW-1:0] inv_r1c3;
    logic [EW-1:0] inv_r2c1;
    logic [EW-1:0] inv_r2c2;
    logic [EW-1:0] inv_r2c3;
    logic [EW-1:0] inv_r3c1;
    logic [EW-1:0] inv_r3c2;
    logic [EW-1:0] inv_r3c3;
    logic          singular;
    logic          clipped;
  } mi3_out_t;

  typedef logic [NE-1:0][EW-1:0] mat_t;

  typedef struct packed {
    logic [2:0][EW-1:0]    row0;
    logic [NE-1:0][CW-1:0] adj;
  } cof_t;

  typedef struct packed {
    logic                   zero;
    logic [MW-1:0]          dmag;
    logic [NE-1:0]          neg;
    logic [NE-1:0]          ovf;
    logic [NE-1:0][MW-1:0]  rem;
    logic [NE-1:0][NQ-1:0]  quo;
  } dstg_t;

endpackage

/* rtl/mi3_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready stream interface carrying one beat of payload type T.
// Depends on nothing; payload types come from mi3_pkg at instantiation.
interface mi3_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/mi3_cofactor.sv */
`timescale 1ns / 1ps
// Three pipeline stages: input register, the eighteen element products and
// the nine adjugate entries. Depends on mi3_pkg.
module mi3_cofactor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  mi3_pkg::mat_t      mat_i,
  output logic               valid_o,
  output mi3_pkg::cof_t      cof_o
);

  logic [2:0] v_q;
  mi3_pkg::mat_t a_q;
  logic [mi3_pkg::NE-1:0][mi3_pkg::PW-1:0] p_q, m_q;
  logic [2:0][mi3_pkg::EW-1:0] r0a_q, r0b_q;
  logic [mi3_pkg::NE-1:0][mi3_pkg::CW-1:0] adj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= mat_i;
      r0a_q <= {a_q[2], a_q[1], a_q[0]};
      r0b_q <= r0a_q;
    end
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      localparam int K  = gi * 3 + gj;
      localparam int PA = ((gj + 1) % 3) * 3 + (gi + 1) % 3;
      localparam int PB = ((gj + 2) % 3) * 3 + (gi + 2) % 3;
      localparam int MA = ((gj + 1) % 3) * 3 + (gi + 2) % 3;
      localparam int MB = ((gj + 2) % 3) * 3 + (gi + 1) % 3;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          p_q[K]   <= $signed(a_q[PA]) * $signed(a_q[PB]);
          m_q[K]   <= $signed(a_q[MA]) * $signed(a_q[MB]);
          adj_q[K] <= mi3_pkg::CW'($signed(p_q[K])) - mi3_pkg::CW'($signed(m_q[K]));
        end
      end
    end
  end

  assign valid_o   = v_q[2];
  assign cof_o.row0 = r0b_q;
  assign cof_o.adj  = adj_q;

endmodule

/* rtl/mi3_det.sv */
`timescale 1ns / 1ps
// Three pipeline stages: split determinant products, their sum, then the
// magnitudes, signs and overflow precheck for the divider. Depends on mi3_pkg.
module mi3_det (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  mi3_pkg::cof_t     cof_i,
  output logic              valid_o,
  output mi3_pkg::dstg_t    div_o
);

  logic [2:0] v_q;
  logic [2:0][mi3_pkg::XW-1:0] lo_q, hi_q;
  logic [mi3_pkg::NE-1:0][mi3_pkg::CW-1:0] adja_q, adjb_q;
  logic [mi3_pkg::DW-1:0] det_q, det_d;
  logic [mi3_pkg::DW-1:0] dabs;
  mi3_pkg::dstg_t out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  for (genvar gj = 0; gj < 3; gj++) begin : g_term
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q[gj] <= $signed(cof_i.row0[gj]) * $signed({1'b0, cof_i.adj[gj*3][31:0]});
        hi_q[gj] <= $signed(cof_i.row0[gj]) * $signed(cof_i.adj[gj*3][mi3_pkg::CW-1:32]);
      end
    end
  end

  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (mi3_pkg::DW'($signed(hi_q[j])) <<< 32)
                    + mi3_pkg::DW'($signed(lo_q[j]));
    end
  end

  always_comb begin
    logic [mi3_pkg::CW-1:0] cabs;
    dabs = det_q[mi3_pkg::DW-1] ? (~det_q + 1'b1) : det_q;
    out_d.zero = (det_q == '0);
    out_d.dmag = dabs[mi3_pkg::MW-1:0];
    out_d.quo  = '0;
    for (int k = 0; k < mi3_pkg::NE; k++) begin
      cabs = adjb_q[k][mi3_pkg::CW-1] ? (~adjb_q[k] + 1'b1) : adjb_q[k];
      out_d.neg[k] = adjb_q[k][mi3_pkg::CW-1] ^ det_q[mi3_pkg::DW-1];
      out_d.rem[k] = mi3_pkg::MW'(cabs[mi3_pkg::CMW-1:0]);
      out_d.ovf[k] = (mi3_pkg::MW'(cabs[mi3_pkg::CMW-1:0]) >= dabs[mi3_pkg::MW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adja_q <= cof_i.adj;
      adjb_q <= adja_q;
      det_q  <= det_d;
      out_q  <= out_d;
    end
  end

  assign valid_o = v_q[2];
  assign div_o   = out_q;

endmodule

/* rtl/mi3_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage for all nine
// lanes against the shared determinant magnitude. Depends on mi3_pkg.
module mi3_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  mi3_pkg::dstg_t    div_i,
  output logic              valid_o,
  output mi3_pkg::dstg_t    div_o
);

  logic [mi3_pkg::NQ-1:0] v_q;
  mi3_pkg::dstg_t st_q [mi3_pkg::NQ];
  mi3_pkg::dstg_t prv  [mi3_pkg::NQ];
  mi3_pkg::dstg_t nxt  [mi3_pkg::NQ];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[mi3_pkg::NQ-2:0], valid_i};
    end
  end

  for (genvar gs = 0; gs < mi3_pkg::NQ; gs++) begin : g_stage
    if (gs == 0) begin : g_first
      assign prv[gs] = div_i;
    end else begin : g_rest
      assign prv[gs] = st_q[gs-1];
    end

    always_comb begin
      logic [mi3_pkg::MW:0] r2;
      logic [mi3_pkg::MW:0] diff;
      logic                 ge;
      nxt[gs] = prv[gs];
      for (int k = 0; k < mi3_pkg::NE; k++) begin
        r2   = {prv[gs].rem[k], 1'b0};
        diff = r2 - {1'b0, prv[gs].dmag};
        ge   = (r2 >= {1'b0, prv[gs].dmag});
        nxt[gs].rem[k] = ge ? diff[mi3_pkg::MW-1:0] : r2[mi3_pkg::MW-1:0];
        nxt[gs].quo[k] = {prv[gs].quo[k][mi3_pkg::NQ-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[gs] <= nxt[gs];
      end
    end
  end

  assign valid_o = v_q[mi3_pkg::NQ-1];
  assign div_o   = st_q[mi3_pkg::NQ-1];

endmodule

/* rtl/matrix_inverse_3x3_core.sv */
`timescale 1ns / 1ps
// 3x3 matrix inverse by the adjugate method on signed Q16.16 elements. The
// core takes one matrix per clock while its output beats are taken. Three
// stages form the adjugate, three the determinant and its magnitude,
// thirty-two each resolve one quotient bit for all nine elements, and the
// last saturates and registers the result beat. When the output beat is
// not taken, the whole pipeline holds and ready drops. A zero determinant
// gives all-zero elements with singular set.
module matrix_inverse_3x3_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  mi3_stream_if.sink    in_i,
  mi3_stream_if.source  out_o
);

  logic en;
  logic cof_v, det_v, div_v;
  mi3_pkg::mat_t  mat;
  mi3_pkg::cof_t  cof;
  mi3_pkg::dstg_t dstg, qres;
  logic out_v_q;
  mi3_pkg::mi3_out_t out_q, out_d;
  logic [mi3_pkg::NE-1:0][mi3_pkg::EW-1:0] res;
  logic [mi3_pkg::NE-1:0] over;

  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  assign mat = {in_i.data.in_r3c3, in_i.data.in_r3c2, in_i.data.in_r3c1,
                in_i.data.in_r2c3, in_i.data.in_r2c2, in_i.data.in_r2c1,
                in_i.data.in_r1c3, in_i.data.in_r1c2, in_i.data.in_r1c1};

  mi3_cofactor u_cof (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .mat_i(mat),
    .valid_o(cof_v), .cof_o(cof)
  );

  mi3_det u_det (
    .clk_i, .rst_ni, .en_i(en), .valid_i(cof_v), .cof_i(cof),
    .valid_o(det_v), .div_o(dstg)
  );

  mi3_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(det_v), .div_i(dstg),
    .valid_o(div_v), .div_o(qres)
  );

  always_comb begin
    for (int k = 0; k < mi3_pkg::NE; k++) begin
      over[k] = qres.ovf[k] ||
                (qres.quo[k] > (qres.neg[k] ? mi3_pkg::NEG_MAX : mi3_pkg::POS_MAX));
      if (qres.zero) begin
        res[k] = '0;
      end else if (over[k]) begin
        res[k] = qres.neg[k] ? mi3_pkg::NEG_MAX : mi3_pkg::POS_MAX;
      end else begin
        res[k] = qres.neg[k] ? (~qres.quo[k] + 1'b1) : qres.quo[k];
      end
    end
    out_d.inv_r1c1 = res[0];
    out_d.inv_r1c2 = res[1];
    out_d.inv_r1c3 = res[2];
    out_d.inv_r2c1 = res[3];
    out_d.inv_r2c2 = res[4];
    out_d.inv_r2c3 = res[5];
    out_d.inv_r3c1 = res[6];
    out_d.inv_r3c2 = res[7];
    out_d.inv_r3c3 = res[8];
    out_d.singular = qres.zero;
    out_d.clipped  = !qres.zero && (|over);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule
